### rtl/utfx_pkg.sv
// ----------------------------------------------------------------------------
// UTF transcoder package
// Shared payload types, configuration codes and constants of the UTF
// transcoder.
// ----------------------------------------------------------------------------
package utfx_pkg;

	localparam int COUNT_BITS_DEF = 24;
	localparam int TOTAL_BITS     = 24;
	localparam int MAX_UNITS      = 4;

	// Encoding codes. Code 3 behaves as UTF-32.
	localparam logic [1:0] FMT_UTF8  = 2'd0;
	localparam logic [1:0] FMT_UTF16 = 2'd1;
	localparam logic [1:0] FMT_UTF32 = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_SOURCE_FORMAT = 3'd0;
	localparam logic [2:0] REG_DEST_FORMAT   = 3'd1;
	localparam logic [2:0] REG_SOURCE_SWAP   = 3'd2;
	localparam logic [2:0] REG_DEST_SWAP     = 3'd3;
	localparam logic [2:0] REG_LIMIT_ENABLE  = 3'd4;
	localparam logic [2:0] REG_DEST_LIMIT    = 3'd5;

	typedef struct packed {
		logic [31:0] src_unit;
		logic        src_last;
	} src_item_t;

	typedef struct packed {
		logic [31:0]           dst_unit;
		logic                  unit_valid;
		logic                  end_mark;
		logic [TOTAL_BITS-1:0] units_total;
	} dst_item_t;

	typedef struct packed {
		logic [1:0]            source_format;
		logic [1:0]            dest_format;
		logic                  source_swap;
		logic                  dest_swap;
		logic                  limit_enable;
		logic [TOTAL_BITS-1:0] dest_limit;
	} cfg_t;

	// Partial sequence kept between source units.
	typedef struct packed {
		logic [20:0] partial_code;
		logic [1:0]  bytes_needed;
		logic [9:0]  high_half;
		logic        high_pending;
	} dec_state_t;

	// Everything one source unit produces, ready to be sent out in order.
	typedef struct packed {
		logic [2:0]                             count;
		logic                                   bare;
		logic                                   last;
		logic [MAX_UNITS-1:0][31:0]             units;
		logic [MAX_UNITS-1:0][TOTAL_BITS-1:0]   totals;
	} step_res_t;

endpackage

### rtl/utfx_step.sv
// ----------------------------------------------------------------------------
// UTF transcoder step logic
// Decodes one source unit against the pending sequence, encodes a finished
// code point, applies the unit limit and works out the running totals.
// ----------------------------------------------------------------------------
module utfx_step #(
	parameter int COUNT_BITS = utfx_pkg::COUNT_BITS_DEF
) (
	input  utfx_pkg::cfg_t       cfg,
	input  utfx_pkg::src_item_t  item,
	input  utfx_pkg::dec_state_t dec,
	input  logic [COUNT_BITS-1:0] written,
	output utfx_pkg::dec_state_t dec_next,
	output logic [COUNT_BITS-1:0] written_next,
	output utfx_pkg::step_res_t  res
);
	import utfx_pkg::*;

	localparam int CW = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	// Saturating add of a small amount to the unit count.
	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
			input logic [2:0] b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + (COUNT_BITS+1)'(b);
		return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	logic             full;
	logic             have;
	logic [31:0]      cp;
	logic [15:0]      w16;
	logic [7:0]       b8;
	logic [20:0]      c;
	logic [19:0]      v;
	logic [2:0]       n;
	logic [3:0][31:0] u;
	logic [CW-1:0]    uw_ext;
	logic [CW-1:0]    lim_ext;
	logic [CW-1:0]    tot_ext;

	assign uw_ext  = CW'(written);
	assign lim_ext = CW'(cfg.dest_limit);
	assign full    = cfg.limit_enable && (uw_ext >= lim_ext);
	assign b8      = item.src_unit[7:0];
	assign w16     = cfg.source_swap ? swap16(item.src_unit[15:0]) : item.src_unit[15:0];

	// Decoder
	always_comb begin
		dec_next = dec;
		have     = 1'b0;
		cp       = '0;
		if (!full) begin
			unique case (cfg.source_format)
				FMT_UTF8: begin
					if (dec.bytes_needed != 2'd0 && b8[7:6] == 2'b10) begin
						if (dec.bytes_needed == 2'd1) begin
							cp = 32'({dec.partial_code[14:0], b8[5:0]});
							have = 1'b1;
							dec_next.partial_code = '0;
						end else begin
							dec_next.partial_code = {dec.partial_code[14:0], b8[5:0]};
						end
						dec_next.bytes_needed = dec.bytes_needed - 2'd1;
					end else begin
						// A broken sequence is dropped and this byte starts afresh.
						if (dec.bytes_needed != 2'd0) begin
							dec_next = '0;
						end
						if (b8[7] == 1'b0) begin
							cp   = 32'(b8);
							have = 1'b1;
						end else if (b8[7:5] == 3'b110) begin
							dec_next.partial_code = 21'(b8[4:0]);
							dec_next.bytes_needed = 2'd1;
						end else if (b8[7:4] == 4'b1110) begin
							dec_next.partial_code = 21'(b8[3:0]);
							dec_next.bytes_needed = 2'd2;
						end else if (b8[7:3] == 5'b11110) begin
							dec_next.partial_code = 21'(b8[2:0]);
							dec_next.bytes_needed = 2'd3;
						end
					end
				end
				FMT_UTF16: begin
					if (dec.high_pending && w16[15:10] == 6'b110111) begin
						cp = 32'({1'b0, dec.high_half, w16[9:0]} + 21'h10000);
						have = 1'b1;
						dec_next = '0;
					end else begin
						if (dec.high_pending) begin
							dec_next = '0;
						end
						if (w16[15:11] != 5'b11011) begin
							cp   = 32'(w16);
							have = 1'b1;
						end else if (w16[10] == 1'b0) begin
							dec_next.high_half    = w16[9:0];
							dec_next.high_pending = 1'b1;
						end
					end
				end
				default: begin
					cp   = cfg.source_swap ? swap32(item.src_unit) : item.src_unit;
					have = 1'b1;
				end
			endcase
		end
		if (item.src_last) begin
			dec_next = '0;
		end
	end

	// Encoder and limit
	always_comb begin
		c = cp[20:0];
		v = 20'(c - 21'h10000);
		n = 3'd0;
		u = '0;
		if (have && cp < 32'h110000) begin
			unique case (cfg.dest_format)
				FMT_UTF8: begin
					if (c < 21'h80) begin
						u[0] = 32'(c);
						n = 3'd1;
					end else if (c < 21'h800) begin
						u[0] = 32'({3'b110, c[10:6]});
						u[1] = 32'({2'b10, c[5:0]});
						n = 3'd2;
					end else if (c < 21'h10000) begin
						u[0] = 32'({4'b1110, c[15:12]});
						u[1] = 32'({2'b10, c[11:6]});
						u[2] = 32'({2'b10, c[5:0]});
						n = 3'd3;
					end else begin
						u[0] = 32'({5'b11110, c[20:18]});
						u[1] = 32'({2'b10, c[17:12]});
						u[2] = 32'({2'b10, c[11:6]});
						u[3] = 32'({2'b10, c[5:0]});
						n = 3'd4;
					end
				end
				FMT_UTF16: begin
					if (c >= 21'h10000) begin
						u[0] = 32'({6'b110110, v[19:10]});
						u[1] = 32'({6'b110111, v[9:0]});
						n = 3'd2;
					end else if (c[15:11] != 5'b11011) begin
						u[0] = 32'(c[15:0]);
						n = 3'd1;
					end
					if (cfg.dest_swap) begin
						u[0] = 32'(swap16(u[0][15:0]));
						u[1] = 32'(swap16(u[1][15:0]));
					end
				end
				default: begin
					u[0] = cfg.dest_swap ? swap32(cp) : cp;
					n = 3'd1;
				end
			endcase
		end
		// A code point that does not fit in the room left is dropped whole.
		if (cfg.limit_enable && (uw_ext + CW'(n) > lim_ext)) begin
			n = 3'd0;
		end
	end

	// Result and count
	always_comb begin
		res        = '0;
		res.units  = u;
		res.last   = item.src_last;
		res.count  = n;
		tot_ext    = '0;
		for (int k = 0; k < MAX_UNITS; k++) begin
			tot_ext = CW'(sat_add(written, 3'(k + 1)));
			res.totals[k] = tot_ext[TOTAL_BITS-1:0];
		end
		if (item.src_last && n == 3'd0) begin
			// Bare end marker carries the count as it stands.
			res.count     = 3'd1;
			res.bare      = 1'b1;
			res.units     = '0;
			tot_ext       = CW'(written);
			res.totals[0] = tot_ext[TOTAL_BITS-1:0];
		end
		if (item.src_last) begin
			written_next = '0;
		end else if (n != 3'd0) begin
			written_next = sat_add(written, n);
		end else begin
			written_next = written;
		end
	end

endmodule

### rtl/unicode_utf_transcoder_unit.sv
// ----------------------------------------------------------------------------
// UTF transcoder, top level
// Converts a stream of UTF-8, UTF-16 or UTF-32 code units into another of
// these encodings, with an optional limit on the number of output units.
// ----------------------------------------------------------------------------
// Usage:
// Source units arrive on the src channel (valid/ready); destination units
// leave on the dst channel (valid/ready), one unit per transfer. A source
// unit is first captured in an input register, then decoded and encoded
// into a result buffer of up to four units, which drains one unit per cycle
// while the receiver is ready and is reloaded from the input register as its
// last unit leaves or when empty. While the receiver is ready and each item
// gives one unit or none, a new source unit can be taken every cycle; an
// item that expands to more units holds the input register until the buffer
// drains, the drain being the limit. The last unit of a text always gives at
// least one transfer, with end_mark set. When the receiver stalls, the
// buffer holds its units and the input register holds the next item, after
// which src_ready drops. The configuration port writes one register per
// clock; the user must use it only while the block is idle, which the block
// does not enforce. Writing source_format drops a pending sequence. Reset
// clears the pending sequence, the unit count and both buffers, and sets the
// registers to their reset values (destination UTF-16).
module unicode_utf_transcoder_unit #(
	parameter int COUNT_BITS = utfx_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [2:0]                          cfg_index,
	input  logic [utfx_pkg::TOTAL_BITS-1:0]     cfg_wdata,
	input  logic                                src_valid,
	output logic                                src_ready,
	input  utfx_pkg::src_item_t                 src,
	output logic                                dst_valid,
	input  logic                                dst_ready,
	output utfx_pkg::dst_item_t                 dst
);
	import utfx_pkg::*;

	cfg_t                  cfg_q;
	dec_state_t            dec_q;
	dec_state_t            dec_next;
	logic [COUNT_BITS-1:0] written_q;
	logic [COUNT_BITS-1:0] written_next;
	src_item_t             src_s1;
	logic                  vld_s1;
	step_res_t             res;
	step_res_t             buf_q;
	logic [2:0]            rem_q;
	logic                  load;
	logic                  dst_xfer;

	assign dst_xfer  = dst_valid && dst_ready;
	assign load      = vld_s1 && ((rem_q == 3'd0) || (rem_q == 3'd1 && dst_ready));
	assign src_ready = !vld_s1 || load;

	utfx_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.cfg         (cfg_q),
		.item        (src_s1),
		.dec         (dec_q),
		.written     (written_q),
		.dec_next    (dec_next),
		.written_next(written_next),
		.res         (res)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{dest_format: FMT_UTF16, default: '0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_FORMAT: cfg_q.source_format <= cfg_wdata[1:0];
				REG_DEST_FORMAT:   cfg_q.dest_format   <= cfg_wdata[1:0];
				REG_SOURCE_SWAP:   cfg_q.source_swap   <= cfg_wdata[0];
				REG_DEST_SWAP:     cfg_q.dest_swap     <= cfg_wdata[0];
				REG_LIMIT_ENABLE:  cfg_q.limit_enable  <= cfg_wdata[0];
				REG_DEST_LIMIT:    cfg_q.dest_limit    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Decoder state and unit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q     <= '0;
			written_q <= '0;
		end else if (cfg_we && cfg_index == REG_SOURCE_FORMAT) begin
			dec_q <= '0;
		end else if (load) begin
			dec_q     <= dec_next;
			written_q <= written_next;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (src_ready) begin
			vld_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_ready && src_valid) begin
			src_s1 <= src;
		end
	end

	// Result buffer; the head entry is the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= res.count;
		end else if (dst_xfer) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res;
		end else if (dst_xfer) begin
			buf_q <= '{count: buf_q.count, bare: buf_q.bare, last: buf_q.last,
				units: {32'd0, buf_q.units[MAX_UNITS-1:1]},
				totals: {{TOTAL_BITS{1'b0}}, buf_q.totals[MAX_UNITS-1:1]}};
		end
	end

	assign dst_valid       = (rem_q != 3'd0);
	assign dst.dst_unit    = buf_q.units[0];
	assign dst.unit_valid  = !buf_q.bare;
	assign dst.end_mark    = buf_q.last && (rem_q == 3'd1);
	assign dst.units_total = buf_q.totals[0];

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UTF transcoder testbench
// Streams UTF-8, UTF-16 and UTF-32 text through the transcoder under a series
// of register settings and checks every destination unit against a built-in
// transcoding predictor, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
	import utfx_pkg::*;

	localparam int         STALL_LIMIT  = 1000;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         HOLD_CYCLES  = 200;
	localparam logic [2:0] REG_NONE     = 3'd7;

	typedef enum int {LIGHT_SENDER, HEAVY_SENDER, NO_IDLE} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [23:0] cfg_wdata = '0;
	logic        src_valid = 1'b0;
	logic        src_ready;
	src_item_t   src = '0;
	logic        dst_valid;
	logic        dst_ready = 1'b0;
	dst_item_t   dst;

	// Predictor state and its copy of the registers.
	cfg_t        shadow_cfg;
	logic [20:0] seq_code;
	logic [1:0]  seq_left;
	logic [9:0]  surr_high;
	logic        surr_wait;
	logic [23:0] units_done;

	src_item_t src_backlog[$];
	dst_item_t expected_units[$];
	int        pushed_count = 0;
	int        accepted_count = 0;
	int        error_count = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        quiet_cycles = 0;
	int        hold_left = 0;
	logic      hold_req = 1'b0;
	logic      hold_used = 1'b0;

	unicode_utf_transcoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src       (src),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst       (dst)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

	function automatic void clear_pending();
		seq_code = '0;
		seq_left = '0;
		surr_high = '0;
		surr_wait = 1'b0;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output logic [31:0] cp);
		cp = '0;
		if (seq_left != 2'd0) begin
			if (b[7:6] == 2'b10) begin
				seq_code = {seq_code[14:0], b[5:0]};
				seq_left--;
				if (seq_left == 2'd0) begin
					cp = 32'(seq_code);
					seq_code = '0;
					return 1'b1;
				end
				return 1'b0;
			end
			// A broken sequence is dropped and this byte starts over.
			clear_pending();
		end
		if (b < 8'h80) begin
			cp = 32'(b);
			return 1'b1;
		end
		if (b < 8'hC0)
			return 1'b0;
		if (b < 8'hE0) begin
			seq_code = 21'(b[4:0]);
			seq_left = 2'd1;
		end else if (b < 8'hF0) begin
			seq_code = 21'(b[3:0]);
			seq_left = 2'd2;
		end else if (b < 8'hF8) begin
			seq_code = 21'(b[2:0]);
			seq_left = 2'd3;
		end
		return 1'b0;
	endfunction

	function automatic bit decode_word(input logic [15:0] w, output logic [31:0] cp);
		cp = '0;
		if (surr_wait) begin
			if (w >= 16'hDC00 && w < 16'hE000) begin
				cp = 32'h10000 + 32'({surr_high, w[9:0]});
				clear_pending();
				return 1'b1;
			end
			clear_pending();
		end
		if (w < 16'hD800 || w > 16'hDFFF) begin
			cp = 32'(w);
			return 1'b1;
		end
		if (w < 16'hDC00) begin
			surr_high = w[9:0];
			surr_wait = 1'b1;
		end
		return 1'b0;
	endfunction

	// Encodes one code point; returns the unit count, zero when it is dropped.
	function automatic int encode_cp(input logic [31:0] cp, input logic [1:0] fmt,
			input logic swap, output logic [3:0][31:0] u);
		logic [31:0] v;
		int n;
		u = '0;
		n = 0;
		if (cp >= 32'h110000)
			return 0;
		case (fmt)
			FMT_UTF8: begin
				if (cp < 32'h80) begin
					u[0] = cp;
					n = 1;
				end else if (cp < 32'h800) begin
					u[0] = 32'hC0 | (cp >> 6);
					u[1] = 32'h80 | (cp & 32'h3F);
					n = 2;
				end else if (cp < 32'h10000) begin
					u[0] = 32'hE0 | (cp >> 12);
					u[1] = 32'h80 | ((cp >> 6) & 32'h3F);
					u[2] = 32'h80 | (cp & 32'h3F);
					n = 3;
				end else begin
					u[0] = 32'hF0 | (cp >> 18);
					u[1] = 32'h80 | ((cp >> 12) & 32'h3F);
					u[2] = 32'h80 | ((cp >> 6) & 32'h3F);
					u[3] = 32'h80 | (cp & 32'h3F);
					n = 4;
				end
			end
			FMT_UTF16: begin
				if (cp >= 32'h10000) begin
					v = cp - 32'h10000;
					u[0] = 32'hD800 + 32'(v[19:10]);
					u[1] = 32'hDC00 + 32'(v[9:0]);
					n = 2;
				end else if (cp >= 32'hD800 && cp <= 32'hDFFF) begin
					return 0;
				end else begin
					u[0] = cp;
					n = 1;
				end
				if (swap)
					for (int k = 0; k < n; k++)
						u[k] = {16'h0, swap16(u[k][15:0])};
			end
			default: begin
				u[0] = swap ? swap32(cp) : cp;
				n = 1;
			end
		endcase
		return n;
	endfunction

	// Works out the destination units of one accepted source unit.
	function automatic void transcode_item(input src_item_t it);
		logic [31:0]      cp;
		logic [3:0][31:0] u;
		logic [3:0][23:0] tot;
		int               n;
		bit               have;
		dst_item_t        e;
		n = 0;
		u = '0;
		tot = '0;
		cp = '0;
		have = 1'b0;
		if (!(shadow_cfg.limit_enable && units_done >= shadow_cfg.dest_limit)) begin
			case (shadow_cfg.source_format)
				FMT_UTF8: have = decode_byte(it.src_unit[7:0], cp);
				FMT_UTF16: have = decode_word(shadow_cfg.source_swap ?
					swap16(it.src_unit[15:0]) : it.src_unit[15:0], cp);
				default: begin
					cp = shadow_cfg.source_swap ? swap32(it.src_unit) : it.src_unit;
					have = 1'b1;
				end
			endcase
			if (have) begin
				n = encode_cp(cp, shadow_cfg.dest_format, shadow_cfg.dest_swap, u);
				// A code point that does not fit in the remaining room is dropped whole.
				if (n > 0 && shadow_cfg.limit_enable &&
						n > int'(shadow_cfg.dest_limit) - int'(units_done))
					n = 0;
				for (int k = 0; k < n; k++) begin
					if (units_done != '1)
						units_done++;
					tot[k] = units_done;
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			e.dst_unit = u[k];
			e.unit_valid = 1'b1;
			e.end_mark = it.src_last && (k == n - 1);
			e.units_total = tot[k];
			expected_units.push_back(e);
		end
		if (it.src_last) begin
			if (n == 0) begin
				e.dst_unit = '0;
				e.unit_valid = 1'b0;
				e.end_mark = 1'b1;
				e.units_total = units_done;
				expected_units.push_back(e);
			end
			clear_pending();
			units_done = '0;
		end
	endfunction

	task automatic flag_error(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Sender: offers queued items, idling at random between transfers.
	always @(posedge clk) begin
		bit took;
		took = src_valid && src_ready;
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else begin
			if (took) begin
				transcode_item(src);
				accepted_count++;
			end
			if (!src_valid || took) begin
				if (src_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					src <= src_backlog.pop_front();
					src_valid <= 1'b1;
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each transfer and throttles dst_ready.
	always @(posedge clk) begin
		dst_item_t want;
		if (!arst_n) begin
			dst_ready <= 1'b0;
		end else begin
			if (dst_valid && dst_ready) begin
				if (expected_units.size() == 0) begin
					flag_error($sformatf("unit %h arrived with nothing expected", dst.dst_unit));
				end else begin
					want = expected_units.pop_front();
					if (dst.dst_unit !== want.dst_unit)
						flag_error($sformatf("dst_unit %h, expected %h",
							dst.dst_unit, want.dst_unit));
					if (dst.unit_valid !== want.unit_valid)
						flag_error($sformatf("unit_valid %b, expected %b",
							dst.unit_valid, want.unit_valid));
					if (dst.end_mark !== want.end_mark)
						flag_error($sformatf("end_mark %b, expected %b",
							dst.end_mark, want.end_mark));
					if (dst.units_total !== want.units_total)
						flag_error($sformatf("units_total %0d, expected %0d",
							dst.units_total, want.units_total));
				end
			end
			// One long hold-off lets the block fill up and stall its input.
			if (hold_req && !hold_used) begin
				hold_used <= 1'b1;
				hold_left <= HOLD_CYCLES;
				dst_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				dst_ready <= 1'b0;
			end else begin
				dst_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (dst_valid && dst_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_unit(input logic [31:0] unit, input logic last);
		src_item_t it;
		it.src_unit = unit;
		it.src_last = last;
		src_backlog.push_back(it);
		pushed_count++;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (accepted_count != pushed_count || expected_units.size() != 0);
		// Items that give no unit may still be in flight.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes one register with random bits above the field, which must be ignored.
	task automatic write_reg(input logic [2:0] idx, input logic [23:0] value);
		logic [23:0] wdata;
		wdata = 24'($urandom());
		case (idx)
			REG_SOURCE_FORMAT, REG_DEST_FORMAT: wdata[1:0] = value[1:0];
			REG_SOURCE_SWAP, REG_DEST_SWAP, REG_LIMIT_ENABLE: wdata[0] = value[0];
			REG_DEST_LIMIT: wdata = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= wdata;
		case (idx)
			REG_SOURCE_FORMAT: begin
				shadow_cfg.source_format = wdata[1:0];
				clear_pending();
			end
			REG_DEST_FORMAT: shadow_cfg.dest_format = wdata[1:0];
			REG_SOURCE_SWAP: shadow_cfg.source_swap = wdata[0];
			REG_DEST_SWAP: shadow_cfg.dest_swap = wdata[0];
			REG_LIMIT_ENABLE: shadow_cfg.limit_enable = wdata[0];
			REG_DEST_LIMIT: shadow_cfg.dest_limit = wdata;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_code_point();
		int r;
		r = $urandom_range(99);
		if (r < 4) begin
			case ($urandom_range(7))
				0: return 32'h0;
				1: return 32'h7F;
				2: return 32'h80;
				3: return 32'h7FF;
				4: return 32'h800;
				5: return 32'hFFFF;
				6: return 32'h10000;
				default: return 32'h10FFFF;
			endcase
		end
		if (r < 30) return $urandom_range(32'h7F);
		if (r < 46) return $urandom_range(32'h7FF, 32'h80);
		if (r < 62) return $urandom_range(32'hFFFF, 32'h800);
		if (r < 70) return $urandom_range(32'hDFFF, 32'hD800);
		if (r < 90) return $urandom_range(32'h10FFFF, 32'h10000);
		// Only a UTF-32 source can carry values past the Unicode range.
		if (shadow_cfg.source_format != FMT_UTF8 && shadow_cfg.source_format != FMT_UTF16)
			return $urandom();
		return $urandom_range(32'h10FFFF);
	endfunction

	// Mostly well-formed text in the current source encoding, with some noise,
	// cut sequences and ends of text at random points.
	task automatic gen_text(input int count);
		logic [31:0]      cp;
		logic [31:0]      unit;
		logic [3:0][31:0] u;
		int               made;
		int               n;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < 12) begin
				push_unit($urandom(), $urandom_range(9) == 0);
				made++;
			end else begin
				cp = pick_code_point();
				n = encode_cp(cp, shadow_cfg.source_format, shadow_cfg.source_swap, u);
				if (n == 0) begin
					// Lone surrogate or out-of-range value, sent as one raw unit.
					if (shadow_cfg.source_format == FMT_UTF16)
						u[0] = 32'(shadow_cfg.source_swap ? swap16(cp[15:0]) : cp[15:0]);
					else
						u[0] = shadow_cfg.source_swap ? swap32(cp) : cp;
					n = 1;
				end
				if (n > 1 && $urandom_range(99) < 10)
					n = $urandom_range(n - 1, 1);
				for (int k = 0; k < n; k++) begin
					unit = u[k];
					if ($urandom_range(1) == 1) begin
						if (shadow_cfg.source_format == FMT_UTF8)
							unit[31:8] = 24'($urandom());
						else if (shadow_cfg.source_format == FMT_UTF16)
							unit[31:16] = 16'($urandom());
					end
					push_unit(unit, $urandom_range(9) == 0);
					made++;
				end
			end
		end
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			LIGHT_SENDER: begin
				send_idle_pct = 28;
				recv_idle_pct = 84;
			end
			HEAVY_SENDER: begin
				send_idle_pct = 84;
				recv_idle_pct = 28;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	task automatic run_phase(input logic [1:0] src_fmt, input logic [1:0] dst_fmt,
			input logic s_swap, input logic d_swap, input logic lim_en,
			input logic [23:0] limit, input int items, input idle_mode_t mode,
			input bit squeeze);
		set_idling(mode);
		write_reg(REG_SOURCE_FORMAT, 24'(src_fmt));
		write_reg(REG_DEST_FORMAT, 24'(dst_fmt));
		write_reg(REG_SOURCE_SWAP, 24'(s_swap));
		write_reg(REG_DEST_SWAP, 24'(d_swap));
		write_reg(REG_LIMIT_ENABLE, 24'(lim_en));
		write_reg(REG_DEST_LIMIT, limit);
		write_reg(REG_NONE, '0);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (squeeze)
			hold_req <= 1'b1;
		gen_text(items);
		wait_drained();
	endtask

	initial begin
		shadow_cfg = '0;
		shadow_cfg.dest_format = FMT_UTF16;
		clear_pending();
		units_done = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed text under the reset settings, UTF-8 to UTF-16.
		set_idling(LIGHT_SENDER);
		push_unit(32'hFFFFFF41, 1'b0);
		push_unit(32'hC3, 1'b0);
		push_unit(32'hA9, 1'b0);
		push_unit(32'hE2, 1'b0);
		push_unit(32'h82, 1'b0);
		push_unit(32'hAC, 1'b0);
		// Four-byte form, which becomes a surrogate pair.
		push_unit(32'hF0, 1'b0);
		push_unit(32'h9F, 1'b0);
		push_unit(32'h98, 1'b0);
		push_unit(32'h80, 1'b0);
		// Overlong zero is accepted as is.
		push_unit(32'hC0, 1'b0);
		push_unit(32'h80, 1'b0);
		// An encoded surrogate decodes, then UTF-16 drops it.
		push_unit(32'hED, 1'b0);
		push_unit(32'hA0, 1'b0);
		push_unit(32'h80, 1'b0);
		// Largest four-byte value is past the Unicode range and dropped.
		push_unit(32'hF7, 1'b0);
		push_unit(32'hBF, 1'b0);
		push_unit(32'hBF, 1'b0);
		push_unit(32'hBF, 1'b0);
		// Bad lead byte and stray continuation byte are skipped.
		push_unit(32'hFF, 1'b0);
		push_unit(32'h80, 1'b0);
		// A broken sequence restarts on the ASCII byte.
		push_unit(32'hE2, 1'b0);
		push_unit(32'h41, 1'b0);
		// End of text in the middle of a sequence leaves a bare end marker.
		push_unit(32'hF0, 1'b0);
		push_unit(32'h9F, 1'b1);
		wait_drained();

		run_phase(FMT_UTF8, FMT_UTF8, 1'b1, 1'b1, 1'b0, 24'h0, 40, LIGHT_SENDER, 1'b0);
		run_phase(FMT_UTF8, FMT_UTF32, 1'b0, 1'b1, 1'b0, 24'h0, 35, LIGHT_SENDER, 1'b0);
		run_phase(FMT_UTF16, FMT_UTF8, 1'b0, 1'b0, 1'b0, 24'h0, 40, LIGHT_SENDER, 1'b0);
		run_phase(FMT_UTF16, FMT_UTF32, 1'b1, 1'b0, 1'b0, 24'h0, 35, LIGHT_SENDER, 1'b0);
		run_phase(FMT_UTF32, FMT_UTF16, 1'b0, 1'b1, 1'b0, 24'h0, 35, HEAVY_SENDER, 1'b0);
		run_phase(FMT_UTF32, FMT_UTF8, 1'b1, 1'b0, 1'b0, 24'h0, 35, HEAVY_SENDER, 1'b0);
		// Format code 3 behaves as UTF-32 on both sides.
		run_phase(2'd3, 2'd3, 1'b1, 1'b1, 1'b0, 24'h0, 30, HEAVY_SENDER, 1'b0);
		run_phase(FMT_UTF8, FMT_UTF8, 1'b0, 1'b0, 1'b1, 24'd5, 40, HEAVY_SENDER, 1'b0);
		run_phase(FMT_UTF16, FMT_UTF8, 1'b1, 1'b0, 1'b1, 24'hFFFFFF, 30, NO_IDLE, 1'b1);
		run_phase(FMT_UTF32, FMT_UTF16, 1'b0, 1'b0, 1'b1, 24'h0, 25, NO_IDLE, 1'b0);
		run_phase(FMT_UTF32, FMT_UTF16, 1'b1, 1'b1, 1'b1, 24'd9, 35, NO_IDLE, 1'b0);
		run_phase(FMT_UTF16, FMT_UTF16, 1'b1, 1'b1, 1'b0, 24'h0, 40, NO_IDLE, 1'b0);

		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
rtl/utfx_pkg.sv
rtl/utfx_step.sv
rtl/unicode_utf_transcoder_unit.sv
test/tb.sv
